// File: rtl/fcts_pkg.sv
// ----------------------------------------------------------------------------
// fcts_pkg
// Shared types and constants of the FCFS CPU/IO tick scheduler.
// ----------------------------------------------------------------------------
package fcts_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned TimeW    = 16;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one input request as it sits in the front queue
  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] interval;
    logic [TimeW-1:0] io_burst;
    logic [TimeW-1:0] cpu_burst;
    logic [TimeW-1:0] arrival;
  } item_t;

  // handoff between front queue and engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  // per-process record
  typedef struct packed {
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] io_len;
    logic [TimeW-1:0] intv;
    logic [TimeW-1:0] ileft;
    logic [TimeW-1:0] ioleft;
    logic [TimeW-1:0] ioend;
    logic [TimeW-1:0] wait_acc;
    logic [IdxW-1:0]  lidx;
  } proc_rec_t;

  // tick result, laid out as out_tdata (lowest field last)
  typedef struct packed {
    logic [3:0]       pad;
    logic             all_done;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] wait_total;
    logic [TimeW-1:0] completion_tick;
    logic             finished;
    logic [IdxW-1:0]  io_proc;
    logic             io_busy;
    logic [IdxW-1:0]  cpu_proc;
    logic             cpu_busy;
    logic [TimeW-1:0] tick_time;
  } result_t;

endpackage

// File: rtl/fcts_front.sv
// ----------------------------------------------------------------------------
// fcts_front
// Input side: takes requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fcts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic                in_tuser,
  output fcts_pkg::front_out_t fq,
  input  logic                pop
);

  fcts_pkg::item_t q_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  fcts_pkg::item_t it;

  // classify and pack the incoming request
  always_comb begin
    it.cmd       = in_tuser;
    it.arrival   = in_tdata[15:0];
    it.cpu_burst = in_tdata[31:16];
    it.io_burst  = in_tdata[47:32];
    it.interval  = in_tdata[63:48];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign fq.valid  = (cnt_r != 2'd0);
  assign fq.item   = q_r[rp_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= it;
  end

endmodule

// File: rtl/fcts_engine.sv
// ----------------------------------------------------------------------------
// fcts_engine
// Back side: sorted process table, ready/IO queues and the tick sequencer.
// ----------------------------------------------------------------------------
module fcts_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcts_pkg::front_out_t fq,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output fcts_pkg::result_t    out_res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ADMIT, ST_IO, ST_CPU, ST_EMIT
  } state_t;

  localparam logic [fcts_pkg::CntW-1:0] Full = fcts_pkg::CntW'(fcts_pkg::MaxProcs);

  state_t                           state_r, state_nxt;
  fcts_pkg::item_t                  cur_r, cur_nxt;
  fcts_pkg::proc_rec_t              proc_r [fcts_pkg::MaxProcs];
  fcts_pkg::proc_rec_t              proc_nxt [fcts_pkg::MaxProcs];
  logic [fcts_pkg::IdxW-1:0]        rdq_r [fcts_pkg::MaxProcs];
  logic [fcts_pkg::IdxW-1:0]        rdq_nxt [fcts_pkg::MaxProcs];
  logic [fcts_pkg::IdxW-1:0]        ioq_r [fcts_pkg::MaxProcs];
  logic [fcts_pkg::IdxW-1:0]        ioq_nxt [fcts_pkg::MaxProcs];
  logic [fcts_pkg::MaxProcs-1:0]    started_r, started_nxt;
  logic [fcts_pkg::MaxProcs-1:0]    rdy_f_r, rdy_f_nxt;
  logic [fcts_pkg::MaxProcs-1:0]    io_f_r, io_f_nxt;
  logic [fcts_pkg::IdxW-1:0]        rd_head_r, rd_head_nxt, io_head_r, io_head_nxt;
  logic [fcts_pkg::CntW-1:0]        rd_cnt_r, rd_cnt_nxt, io_cnt_r, io_cnt_nxt;
  logic [fcts_pkg::CntW-1:0]        cnt_r, cnt_nxt, work_r, work_nxt;
  logic [fcts_pkg::CntW-1:0]        idx_r, idx_nxt;
  logic [fcts_pkg::IdxW-1:0]        pos_r, pos_nxt;
  logic [fcts_pkg::TimeW-1:0]       time_r, time_nxt;
  logic                             ticking_r, ticking_nxt;
  fcts_pkg::result_t                res_r, res_nxt, od_r, od_nxt;
  logic                             ov_r, ov_nxt;

  fcts_pkg::proc_rec_t              e;
  logic [fcts_pkg::IdxW-1:0]        p;
  logic [fcts_pkg::TimeW:0]         wsum;
  logic [fcts_pkg::TimeW-1:0]       w, ileft_n, rem_n;

  assign out_tvalid = ov_r;
  assign out_res    = od_r;

  // next-state logic of the sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    proc_nxt    = proc_r;
    rdq_nxt     = rdq_r;
    ioq_nxt     = ioq_r;
    started_nxt = started_r;
    rdy_f_nxt   = rdy_f_r;
    io_f_nxt    = io_f_r;
    rd_head_nxt = rd_head_r;
    io_head_nxt = io_head_r;
    rd_cnt_nxt  = rd_cnt_r;
    io_cnt_nxt  = io_cnt_r;
    cnt_nxt     = cnt_r;
    work_nxt    = work_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    time_nxt    = time_r;
    ticking_nxt = ticking_r;
    res_nxt     = res_r;
    od_nxt      = od_r;
    ov_nxt      = ov_r && !out_tready;
    pop         = 1'b0;
    e           = '0;
    p           = '0;
    wsum        = '0;
    w           = '0;
    ileft_n     = '0;
    rem_n       = '0;
    case (state_r)
      ST_IDLE: begin
        if (fq.valid) begin
          pop     = 1'b1;
          cur_nxt = fq.item;
          if (fq.item.cmd == fcts_pkg::CMD_TICK) begin
            ticking_nxt       = 1'b1;
            res_nxt           = '0;
            res_nxt.tick_time = time_r;
            idx_nxt           = '0;
            state_nxt         = ST_ADMIT;
          end else if (!ticking_r && cnt_r != Full) begin
            pos_nxt   = cnt_r[fcts_pkg::IdxW-1:0];
            state_nxt = ST_LOAD;
          end
        end
      end
      // insertion: shift later arrivals up one entry per cycle
      ST_LOAD: begin
        e = proc_r[pos_r - 1'b1];
        if (pos_r != '0 && e.arrival > cur_r.arrival) begin
          proc_nxt[pos_r] = e;
          pos_nxt         = pos_r - 1'b1;
        end else begin
          proc_nxt[pos_r].arrival   = cur_r.arrival;
          proc_nxt[pos_r].remaining = cur_r.cpu_burst;
          proc_nxt[pos_r].io_len    = cur_r.io_burst;
          proc_nxt[pos_r].intv      = cur_r.interval;
          proc_nxt[pos_r].ileft     = cur_r.interval;
          proc_nxt[pos_r].ioleft    = cur_r.io_burst;
          proc_nxt[pos_r].ioend     = '0;
          proc_nxt[pos_r].wait_acc  = '0;
          proc_nxt[pos_r].lidx      = cnt_r[fcts_pkg::IdxW-1:0];
          cnt_nxt = cnt_r + 1'b1;
          if (cur_r.cpu_burst != '0) work_nxt = work_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // admission scan in arrival order
      ST_ADMIT: begin
        p = idx_r[fcts_pkg::IdxW-1:0];
        e = proc_r[p];
        if (idx_r < cnt_r && e.arrival <= time_r) begin
          if (e.remaining != '0 && !io_f_r[p] && !rdy_f_r[p]) begin
            if (rd_cnt_r != Full) begin
              rdq_nxt[rd_head_r + rd_cnt_r[fcts_pkg::IdxW-1:0]] = p;
              rd_cnt_nxt = rd_cnt_r + 1'b1;
            end
            rdy_f_nxt[p] = 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = ST_IO;
        end
      end
      // one unit of IO for the head of the IO queue
      ST_IO: begin
        if (io_cnt_r != '0) begin
          p = ioq_r[io_head_r];
          e = proc_r[p];
          res_nxt.io_busy = 1'b1;
          res_nxt.io_proc = e.lidx;
          if (e.ioleft <= 16'd1) begin
            io_head_nxt           = io_head_r + 1'b1;
            io_cnt_nxt            = io_cnt_r - 1'b1;
            io_f_nxt[p]           = 1'b0;
            proc_nxt[p].ioend     = time_r;
            proc_nxt[p].ioleft    = e.io_len;
          end else begin
            proc_nxt[p].ioleft = e.ioleft - 1'b1;
          end
        end
        state_nxt = ST_CPU;
      end
      // one unit of CPU for the head of the ready queue
      ST_CPU: begin
        if (rd_cnt_r != '0) begin
          p = rdq_r[rd_head_r];
          e = proc_r[p];
          res_nxt.cpu_busy = 1'b1;
          res_nxt.cpu_proc = e.lidx;
          w = e.wait_acc;
          if (!started_r[p]) begin
            started_nxt[p] = 1'b1;
            w = time_r - e.arrival;
          end else if (!io_f_r[p] && e.intv != '0 && e.ileft == e.intv &&
                       time_r > e.ioend) begin
            wsum = {1'b0, e.wait_acc} + {1'b0, time_r - e.ioend - 1'b1};
            w    = wsum[fcts_pkg::TimeW] ? fcts_pkg::TimeMax : wsum[fcts_pkg::TimeW-1:0];
          end
          ileft_n = (e.ileft != '0) ? e.ileft - 1'b1 : e.ileft;
          rem_n   = (e.remaining != '0) ? e.remaining - 1'b1 : e.remaining;
          if (rem_n == '0) begin
            rd_head_nxt             = rd_head_r + 1'b1;
            rd_cnt_nxt              = rd_cnt_r - 1'b1;
            rdy_f_nxt[p]            = 1'b0;
            work_nxt                = work_r - 1'b1;
            res_nxt.finished        = 1'b1;
            res_nxt.completion_tick = time_r;
            res_nxt.wait_total      = w;
            res_nxt.turnaround      = time_r - e.arrival;
          end else if (e.intv != '0 && ileft_n == '0) begin
            rd_head_nxt  = rd_head_r + 1'b1;
            rd_cnt_nxt   = rd_cnt_r - 1'b1;
            rdy_f_nxt[p] = 1'b0;
            io_f_nxt[p]  = 1'b1;
            if (io_cnt_nxt != Full) begin
              ioq_nxt[io_head_nxt + io_cnt_nxt[fcts_pkg::IdxW-1:0]] = p;
              io_cnt_nxt = io_cnt_nxt + 1'b1;
            end
            ileft_n = e.intv;
          end
          proc_nxt[p].wait_acc  = w;
          proc_nxt[p].ileft     = ileft_n;
          proc_nxt[p].remaining = rem_n;
        end
        res_nxt.all_done = (work_nxt == '0);
        if (time_r != fcts_pkg::TimeMax) time_nxt = time_r + 1'b1;
        state_nxt = ST_EMIT;
      end
      // hand the result to the output register
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= '0;
      rdy_f_r   <= '0;
      io_f_r    <= '0;
      rd_head_r <= '0;
      io_head_r <= '0;
      rd_cnt_r  <= '0;
      io_cnt_r  <= '0;
      cnt_r     <= '0;
      work_r    <= '0;
      time_r    <= '0;
      ticking_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      rdy_f_r   <= rdy_f_nxt;
      io_f_r    <= io_f_nxt;
      rd_head_r <= rd_head_nxt;
      io_head_r <= io_head_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      io_cnt_r  <= io_cnt_nxt;
      cnt_r     <= cnt_nxt;
      work_r    <= work_nxt;
      time_r    <= time_nxt;
      ticking_r <= ticking_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    proc_r <= proc_nxt;
    rdq_r  <= rdq_nxt;
    ioq_r  <= ioq_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
    od_r   <= od_nxt;
  end

endmodule

// File: rtl/fcfs_cpu_io_tick_scheduler.sv
// ----------------------------------------------------------------------------
// fcfs_cpu_io_tick_scheduler
// First-come-first-served CPU scheduler with IO bursts, one tick per tick request.
// ----------------------------------------------------------------------------
// usage:
//   in_* carries requests: in_tuser = 0 loads a process descriptor, 1 runs
//   one time tick. load requests give no result; each tick gives one result
//   on out_*. loads after the first tick, or beyond 16 processes, are dropped.
//   a two-entry front queue takes requests while the engine works, and the
//   engine stalls on its own when that queue is empty.
//   a load shifts each later table entry up by one entry to keep arrival
//   order; a tick scans the process table in sequence for admission, then
//   runs the IO step, the CPU step and the hand-off to the output register.
//   results sit in an output register; while the receiver stalls, the engine
//   holds its next result and the front queue keeps taking requests until
//   full. reset empties both queues, clears the table and sets time to zero.
// ----------------------------------------------------------------------------
module fcfs_cpu_io_tick_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // arrival, cpu_burst, io_burst, interval
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // tick_time, cpu_busy, cpu_proc, io_busy,
                                  // io_proc, finished, completion_tick,
                                  // wait_total, turnaround, all_done
);

  fcts_pkg::front_out_t fq;
  fcts_pkg::result_t    res;
  logic                 pop;

  fcts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fq        (fq),
    .pop       (pop)
  );

  fcts_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fq         (fq),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FCFS CPU/IO tick scheduler: loads a process
// table, then streams tick requests under random sender bursts and receiver
// stalls, predicting every tick result and comparing it field by field.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // arrival, cpu_burst, io_burst, interval
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // tick_time, cpu_busy, cpu_proc, io_busy, io_proc,
                           // finished, completion_tick, wait_total,
                           // turnaround, all_done

  fcfs_cpu_io_tick_scheduler uut (.*);

  typedef struct packed {
    logic                      cmd;
    logic [fcts_pkg::TimeW-1:0] interval;
    logic [fcts_pkg::TimeW-1:0] io_burst;
    logic [fcts_pkg::TimeW-1:0] cpu_burst;
    logic [fcts_pkg::TimeW-1:0] arrival;
  } request_t;

  request_t           pending_q[$];
  fcts_pkg::result_t  tick_results_q[$];

  // scheduler shadow state
  int unsigned sh_arr[fcts_pkg::MaxProcs], sh_rem[fcts_pkg::MaxProcs];
  int unsigned sh_iolen[fcts_pkg::MaxProcs], sh_intv[fcts_pkg::MaxProcs];
  int unsigned sh_ileft[fcts_pkg::MaxProcs], sh_ioleft[fcts_pkg::MaxProcs];
  int unsigned sh_ioend[fcts_pkg::MaxProcs], sh_wait[fcts_pkg::MaxProcs];
  int unsigned sh_lidx[fcts_pkg::MaxProcs];
  bit          sh_started[fcts_pkg::MaxProcs], sh_inrdy[fcts_pkg::MaxProcs];
  bit          sh_inio[fcts_pkg::MaxProcs];
  int unsigned ready_fifo_q[$], io_fifo_q[$];
  int unsigned sched_time, n_loaded;
  bit          ticks_begun;

  int unsigned mismatches;
  int unsigned idle_cycles;
  logic        in_tready_seen;

  function automatic int unsigned sat_time(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > fcts_pkg::TimeMax) ? fcts_pkg::TimeMax : int'(s);
  endfunction

  // append a request to the driver queue
  task automatic enqueue(request_t r);
    pending_q = {pending_q, r};
  endtask

  // insert a process keeping arrival order, ties in load order
  task automatic load_process(request_t r);
    int unsigned pos;
    if (ticks_begun || n_loaded >= fcts_pkg::MaxProcs) return;
    pos = n_loaded;
    while (pos > 0 && sh_arr[pos-1] > r.arrival) pos--;
    for (int unsigned i = n_loaded; i > pos; i--) begin
      sh_arr[i] = sh_arr[i-1];     sh_rem[i] = sh_rem[i-1];
      sh_iolen[i] = sh_iolen[i-1]; sh_intv[i] = sh_intv[i-1];
      sh_ileft[i] = sh_ileft[i-1]; sh_ioleft[i] = sh_ioleft[i-1];
      sh_ioend[i] = sh_ioend[i-1]; sh_wait[i] = sh_wait[i-1];
      sh_lidx[i] = sh_lidx[i-1];
    end
    sh_arr[pos] = r.arrival;     sh_rem[pos] = r.cpu_burst;
    sh_iolen[pos] = r.io_burst;  sh_intv[pos] = r.interval;
    sh_ileft[pos] = r.interval;  sh_ioleft[pos] = r.io_burst;
    sh_ioend[pos] = 0;           sh_wait[pos] = 0;
    sh_lidx[pos] = n_loaded;
    n_loaded++;
  endtask

  // one time tick: admission, IO device, then CPU
  task automatic run_tick(output fcts_pkg::result_t res);
    int unsigned t, p;
    bit          done;
    t = sched_time;
    done = 1'b1;
    ticks_begun = 1'b1;
    res = '0;
    res.tick_time = fcts_pkg::TimeW'(t);
    for (int unsigned i = 0; i < n_loaded && sh_arr[i] <= t; i++) begin
      if (sh_rem[i] > 0 && !sh_inio[i] && !sh_inrdy[i]) begin
        if (ready_fifo_q.size() < fcts_pkg::MaxProcs) ready_fifo_q = {ready_fifo_q, i};
        sh_inrdy[i] = 1'b1;
      end
    end
    // io device
    if (io_fifo_q.size() > 0) begin
      p = io_fifo_q[0];
      res.io_busy = 1'b1;
      res.io_proc = fcts_pkg::IdxW'(sh_lidx[p]);
      if (sh_ioleft[p] <= 1) begin
        void'(io_fifo_q.pop_front());
        sh_inio[p] = 1'b0;
        sh_ioend[p] = t;
        sh_ioleft[p] = sh_iolen[p];
      end else begin
        sh_ioleft[p]--;
      end
    end
    // cpu
    if (ready_fifo_q.size() > 0) begin
      p = ready_fifo_q[0];
      res.cpu_busy = 1'b1;
      res.cpu_proc = fcts_pkg::IdxW'(sh_lidx[p]);
      if (!sh_started[p]) begin
        sh_started[p] = 1'b1;
        sh_wait[p] = sat_time(0, t - sh_arr[p]);
      end else if (!sh_inio[p] && sh_intv[p] != 0 && sh_ileft[p] == sh_intv[p]) begin
        // back from io: count the ticks spent waiting in the ready queue
        if (t > sh_ioend[p]) sh_wait[p] = sat_time(sh_wait[p], t - sh_ioend[p] - 1);
      end
      if (sh_ileft[p] > 0) sh_ileft[p]--;
      if (sh_rem[p] > 0) sh_rem[p]--;
      if (sh_rem[p] == 0) begin
        void'(ready_fifo_q.pop_front());
        sh_inrdy[p] = 1'b0;
        res.finished = 1'b1;
        res.completion_tick = fcts_pkg::TimeW'(t);
        res.wait_total = fcts_pkg::TimeW'(sh_wait[p]);
        res.turnaround = fcts_pkg::TimeW'(t - sh_arr[p]);
      end else if (sh_intv[p] != 0 && sh_ileft[p] == 0) begin
        void'(ready_fifo_q.pop_front());
        sh_inrdy[p] = 1'b0;
        sh_inio[p] = 1'b1;
        if (io_fifo_q.size() < fcts_pkg::MaxProcs) io_fifo_q = {io_fifo_q, p};
        sh_ileft[p] = sh_intv[p];
      end
    end
    for (int unsigned i = 0; i < n_loaded; i++)
      if (sh_rem[i] > 0) done = 1'b0;
    res.all_done = done;
    sched_time = sat_time(sched_time, 1);
  endtask

  function automatic request_t make_load(int unsigned a, int unsigned b,
                                         int unsigned io, int unsigned iv);
    request_t r;
    r.cmd = fcts_pkg::CMD_LOAD;
    r.arrival = fcts_pkg::TimeW'(a);  r.cpu_burst = fcts_pkg::TimeW'(b);
    r.io_burst = fcts_pkg::TimeW'(io); r.interval = fcts_pkg::TimeW'(iv);
    return r;
  endfunction

  function automatic request_t make_tick();
    request_t r;
    r = '0;
    r.cmd = fcts_pkg::CMD_TICK;
    r.arrival = fcts_pkg::TimeW'($urandom);  r.cpu_burst = fcts_pkg::TimeW'($urandom);
    r.io_burst = fcts_pkg::TimeW'($urandom); r.interval = fcts_pkg::TimeW'($urandom);
    return r;
  endfunction

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // sender: bursts of random length with random gaps
  int unsigned burst_left, gap_left;
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_tready_seen)) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
        request_t r;
        r = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= r.cmd;
        in_tdata  <= {r.interval, r.io_burst, r.cpu_burst, r.arrival};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern with random period and duty, sometimes never stalling
  int unsigned stall_phase, stall_period, stall_duty;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 63) begin
      stall_period <= $urandom_range(2, 9);
      stall_duty   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    out_tready <= (stall_phase % stall_period) >= stall_duty;
  end

  // request acceptance and result checking at the rising edge
  always @(posedge clk) begin
    request_t          acc;
    fcts_pkg::result_t got, want;
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      acc.cmd = in_tuser;
      {acc.interval, acc.io_burst, acc.cpu_burst, acc.arrival} = in_tdata;
      if (acc.cmd == fcts_pkg::CMD_LOAD) begin
        load_process(acc);
      end else begin
        run_tick(want);
        tick_results_q = {tick_results_q, want};
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tick result %h", out_tdata);
      end else begin
        want = tick_results_q.pop_front();
        if (got.tick_time !== want.tick_time || got.cpu_busy !== want.cpu_busy ||
            got.cpu_proc !== want.cpu_proc || got.io_busy !== want.io_busy ||
            got.io_proc !== want.io_proc || got.finished !== want.finished ||
            got.completion_tick !== want.completion_tick ||
            got.wait_total !== want.wait_total ||
            got.turnaround !== want.turnaround || got.all_done !== want.all_done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tick %0d: exp cpu %b/%0d io %b/%0d fin %b c %0d w %0d ta %0d done %b",
                     want.tick_time, want.cpu_busy, want.cpu_proc, want.io_busy,
                     want.io_proc, want.finished, want.completion_tick,
                     want.wait_total, want.turnaround, want.all_done);
            $display("  got t %0d cpu %b/%0d io %b/%0d fin %b c %0d w %0d ta %0d done %b",
                     got.tick_time, got.cpu_busy, got.cpu_proc, got.io_busy,
                     got.io_proc, got.finished, got.completion_tick,
                     got.wait_total, got.turnaround, got.all_done);
          end
        end
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 3000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = fcts_pkg::CMD_LOAD;
    in_tdata = '0;
    out_tready = 1'b0;
    in_tready_seen = 1'b0;
    burst_left = 1; gap_left = 0;
    stall_phase = 0; stall_period = 4; stall_duty = 0;
    mismatches = 0; idle_cycles = 0;
    sched_time = 0; n_loaded = 0; ticks_begun = 1'b0;
    for (int i = 0; i < fcts_pkg::MaxProcs; i++) begin
      sh_started[i] = 1'b0; sh_inrdy[i] = 1'b0; sh_inio[i] = 1'b0;
    end

    // directed loads: zero burst, far arrival, zero io, zero interval, ties
    enqueue(make_load(5, 12, 3, 4));
    enqueue(make_load(0, 0, 2, 2));
    enqueue(make_load(16'hFFFF, 0, 1, 1));
    enqueue(make_load(0, 8, 0, 3));
    enqueue(make_load(3, 25, 2, 0));
    enqueue(make_load(5, 6, 1, 1));
    enqueue(make_load(1, 1, 4, 16'h8000));
    for (int i = 0; i < 9; i++)
      enqueue(make_load($urandom_range(0, 120), $urandom_range(1, 40),
                        $urandom_range(1, 8), $urandom_range(1, 10)));
    // table already full: dropped
    enqueue(make_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // ticks, with stray loads that must be ignored once ticking has begun
    for (int i = 0; i < 1140; i++) begin
      if ($urandom_range(0, 19) == 0)
        enqueue(make_load($urandom, $urandom, $urandom, $urandom));
      else
        enqueue(make_tick());
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    wait (pending_q.size() == 0 && !in_tvalid);
    wait (tick_results_q.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
